// ===== hw/rtl/sfa_pkg.sv =====
// Package for the saturating fixed-point ALU.
// Holds the command codes, the queue entry type and the 32-bit limits.
// It has no dependencies. Every other file but sfa_if imports it.
package sfa_pkg;

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_FROM_INT = 4'd4,
    CMD_TO_INT   = 4'd5,
    CMD_COMPARE  = 4'd6,
    CMD_MIN      = 4'd7,
    CMD_MAX      = 4'd8,
    CMD_INC      = 4'd9,
    CMD_DEC      = 4'd10,
    CMD_NOP      = 4'd15
  } cmd_e;

  localparam logic [31:0] FX_MAX = 32'h7fff_ffff;
  localparam logic [31:0] FX_MIN = 32'h8000_0000;

  localparam int QUEUE_DEPTH = 2;

  // One decoded operation as it waits between the front end and the back end.
  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] a;
    logic [31:0] b;
    logic        div_zero;
  } sfa_entry_t;

endpackage

// ===== hw/rtl/sfa_if.sv =====
// Handshake interfaces for the input and result channels of the ALU.
// Payload fields are plain signals next to valid and ready.
// No dependencies.
interface sfa_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic [31:0] operand_a;
  logic [31:0] operand_b;

  modport source (output valid, command, operand_a, operand_b, input ready);
  modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

interface sfa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  logic        saturated;
  logic        divide_by_zero;
  logic        less;
  logic        equal;
  logic        greater;

  modport source (output valid, result, saturated, divide_by_zero, less, equal, greater,
                  input ready);
  modport sink   (input valid, result, saturated, divide_by_zero, less, equal, greater,
                  output ready);
endinterface

// ===== hw/rtl/sfa_front.sv =====
// Front end: takes operations from the input channel and decodes them.
// Unknown commands become a no-op, and a divide by zero is flagged here.
// Depends on sfa_pkg and sfa_if.
module sfa_front import sfa_pkg::*; (
  sfa_in_if.sink     in_if,
  output logic       push_o,
  input  logic       full_i,
  output sfa_entry_t entry_o
);

  cmd_e cmd;

  always_comb begin
    case (in_if.command) inside
      [4'd0:4'd10]: cmd = cmd_e'(in_if.command);
      default:      cmd = CMD_NOP;
    endcase
  end

  assign in_if.ready      = !full_i;
  assign push_o           = in_if.valid && !full_i;
  assign entry_o.cmd      = cmd;
  assign entry_o.a        = in_if.operand_a;
  assign entry_o.b        = in_if.operand_b;
  assign entry_o.div_zero = (cmd == CMD_DIV) && (in_if.operand_b == 32'd0);

endmodule

// ===== hw/rtl/sfa_queue.sv =====
// Short queue between the front end and the back end.
// Registered storage with read and write pointers; depth from sfa_pkg.
// Depends on sfa_pkg.
module sfa_queue import sfa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  sfa_entry_t entry_i,
  output logic       full_o,
  output logic       valid_o,
  input  logic       pop_i,
  output sfa_entry_t entry_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  sfa_entry_t       mem_q [QUEUE_DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [PW:0]      count_q;

  assign full_o  = (count_q == (PW+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      count_q <= count_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

endmodule

// ===== hw/rtl/sfa_back.sv =====
// Back end: operand stage with the product register and a bit-serial divider,
// then the result register that drives the output channel.
// Depends on sfa_pkg and sfa_if.
module sfa_back import sfa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  output logic       q_pop_o,
  input  sfa_entry_t q_entry_i,
  sfa_out_if.source  out_if
);

  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam logic [63:0] RMASK = (64'd1 << FRAC_BITS) - 64'd1;
  localparam logic signed [31:0] FI_HI = $signed(FX_MAX) >>> FRAC_BITS;
  localparam logic signed [31:0] FI_LO = $signed(FX_MIN) >>> FRAC_BITS;

  sfa_entry_t         s1_q;
  logic               s1_valid_q;
  logic signed [63:0] prod_q;
  logic [32:0]        rem_q;
  logic [DW-1:0]      quo_q;
  logic [31:0]        dvs_q;
  logic [CW-1:0]      cnt_q;

  logic               s1_done, s1_adv, load;
  logic [31:0]        abs_a, abs_b;
  logic [32:0]        shifted;
  logic               fits;

  logic [31:0]        res_d;
  logic               sat_d, dz_d, lt_d, eq_d, gt_d;
  logic [32:0]        sum33;
  logic [63:0]        adj64, sh64;
  logic [32:0]        t33;
  logic signed [32:0] t33s;
  logic               neg;

  logic               out_valid_q;
  logic [31:0]        res_q;
  logic               sat_q, dz_q, lt_q, eq_q, gt_q;

  assign s1_done = (cnt_q == '0);
  assign s1_adv  = s1_valid_q && s1_done && (!out_valid_q || out_if.ready);
  assign load    = q_valid_i && (!s1_valid_q || s1_adv);
  assign q_pop_o = load;

  assign abs_a = q_entry_i.a[31] ? 32'(-q_entry_i.a) : q_entry_i.a;
  assign abs_b = q_entry_i.b[31] ? 32'(-q_entry_i.b) : q_entry_i.b;

  // Restoring division, one quotient bit per cycle.
  assign shifted = {rem_q[31:0], quo_q[DW-1]};
  assign fits    = (shifted >= {1'b0, dvs_q});

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_q   <= q_entry_i;
      prod_q <= $signed(q_entry_i.a) * $signed(q_entry_i.b);
      rem_q  <= '0;
      quo_q  <= {abs_a, {FRAC_BITS{1'b0}}};
      dvs_q  <= abs_b;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? (shifted - {1'b0, dvs_q}) : shifted;
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      if (load) begin
        s1_valid_q <= 1'b1;
        cnt_q      <= (q_entry_i.cmd == CMD_DIV && !q_entry_i.div_zero) ? CW'(DW) : '0;
      end else begin
        if (s1_adv) begin
          s1_valid_q <= 1'b0;
        end
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_d = '0;
    sat_d = 1'b0;
    dz_d  = 1'b0;
    lt_d  = 1'b0;
    eq_d  = 1'b0;
    gt_d  = 1'b0;
    sum33 = '0;
    adj64 = '0;
    sh64  = '0;
    t33   = '0;
    t33s  = '0;
    neg   = s1_q.a[31] ^ s1_q.b[31];
    case (s1_q.cmd)
      CMD_ADD, CMD_SUB: begin
        if (s1_q.cmd == CMD_ADD) begin
          sum33 = {s1_q.a[31], s1_q.a} + {s1_q.b[31], s1_q.b};
        end else begin
          sum33 = {s1_q.a[31], s1_q.a} - {s1_q.b[31], s1_q.b};
        end
        sat_d = sum33[32] != sum33[31];
        res_d = sat_d ? (sum33[32] ? FX_MIN : FX_MAX) : sum33[31:0];
      end
      CMD_MUL: begin
        // Round toward zero before the arithmetic shift.
        adj64 = prod_q + (prod_q[63] ? RMASK : 64'd0);
        sh64  = 64'($signed(adj64) >>> FRAC_BITS);
        sat_d = !((&sh64[63:31]) || !(|sh64[63:31]));
        res_d = sat_d ? (sh64[63] ? FX_MIN : FX_MAX) : sh64[31:0];
      end
      CMD_DIV: begin
        if (s1_q.div_zero) begin
          dz_d = 1'b1;
        end else if (!neg) begin
          sat_d = quo_q > DW'(FX_MAX);
          res_d = sat_d ? FX_MAX : quo_q[31:0];
        end else begin
          sat_d = quo_q > DW'(FX_MIN);
          res_d = sat_d ? FX_MIN : 32'(-quo_q[31:0]);
        end
      end
      CMD_FROM_INT: begin
        if ($signed(s1_q.a) > FI_HI) begin
          sat_d = 1'b1;
          res_d = FX_MAX;
        end else if ($signed(s1_q.a) < FI_LO) begin
          sat_d = 1'b1;
          res_d = FX_MIN;
        end else begin
          res_d = s1_q.a << FRAC_BITS;
        end
      end
      CMD_TO_INT: begin
        t33   = {s1_q.a[31], s1_q.a} + (s1_q.a[31] ? RMASK[32:0] : 33'd0);
        t33s  = $signed(t33) >>> FRAC_BITS;
        res_d = t33s[31:0];
      end
      CMD_COMPARE: begin
        lt_d = $signed(s1_q.a) < $signed(s1_q.b);
        eq_d = s1_q.a == s1_q.b;
        gt_d = $signed(s1_q.a) > $signed(s1_q.b);
      end
      CMD_MIN: res_d = ($signed(s1_q.a) < $signed(s1_q.b)) ? s1_q.a : s1_q.b;
      CMD_MAX: res_d = ($signed(s1_q.a) > $signed(s1_q.b)) ? s1_q.a : s1_q.b;
      CMD_INC: res_d = s1_q.a + 32'd1;
      CMD_DEC: res_d = s1_q.a - 32'd1;
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res_d;
      sat_q <= sat_d;
      dz_q  <= dz_d;
      lt_q  <= lt_d;
      eq_q  <= eq_d;
      gt_q  <= gt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.result         = res_q;
  assign out_if.saturated      = sat_q;
  assign out_if.divide_by_zero = dz_q;
  assign out_if.less           = lt_q;
  assign out_if.equal          = eq_q;
  assign out_if.greater        = gt_q;

endmodule

// ===== hw/rtl/saturating_fixed_point_alu.sv =====
// Saturating signed 32-bit fixed-point ALU with FRAC_BITS fraction bits.
// Built from sfa_front, sfa_queue and sfa_back; uses sfa_pkg and sfa_if.
//
// Usage:
//   Operations enter on in_if (command, operand_a, operand_b) and one result
//   per operation leaves on out_if, in order. A transfer happens on a clock
//   edge where valid and ready are both high.
//   The front end decodes the command and writes a two-entry queue; the back
//   end reads it into an operand stage and then into the result register.
//   A result becomes valid after the queue, the operand stage and the result
//   register; divide also waits in the operand stage while the restoring
//   divider of the back end makes one quotient bit per cycle.
//   Throughput is one operation per cycle for all commands but divide while
//   out_if.ready is high; a divide holds the operand stage until it ends.
//   The queue keeps accepting while the back end divides or the result is
//   stalled, until both entries are full; then in_if.ready drops.
//   When the receiver holds out_if.ready low, the result stays valid and
//   unchanged. Reset empties the queue and the pipeline; nothing else is kept.
module saturating_fixed_point_alu import sfa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input logic       clk_i,
  input logic       rst_ni,
  sfa_in_if.sink    in_if,
  sfa_out_if.source out_if
);

  logic       push, full, q_valid, q_pop;
  sfa_entry_t push_entry, head_entry;

  sfa_front u_front (
    .in_if   (in_if),
    .push_o  (push),
    .full_i  (full),
    .entry_o (push_entry)
  );

  sfa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (head_entry)
  );

  sfa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .q_entry_i (head_entry),
    .out_if    (out_if)
  );

  a_dz_not_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !(out_if.divide_by_zero && out_if.saturated))
    else $error("divide by zero reported together with saturation");

  a_cmp_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> $onehot0({out_if.less, out_if.equal, out_if.greater}))
    else $error("more than one compare flag set");

  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.saturated) |->
      (out_if.result == FX_MAX || out_if.result == FX_MIN))
    else $error("saturated result is not a 32-bit limit");

endmodule

// ===== tb/tb_saturating_fixed_point_alu.sv =====
// Testbench for the saturating fixed-point ALU: directed and random operations,
// each result compared against a behavioral prediction of the arithmetic.
// Depends on sfa_pkg, sfa_if and the saturating_fixed_point_alu RTL.
module tb_saturating_fixed_point_alu;
  import sfa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 8;
  localparam longint LIM_HI = 64'sd2147483647;
  localparam longint LIM_LO = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] result;
    logic        saturated;
    logic        divide_by_zero;
    logic        less;
    logic        equal;
    logic        greater;
  } alu_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycle_cnt = 0;
  int   fail_cnt = 0;
  bit   no_idle = 1'b0;

  alu_result_t pending_results[$];

  sfa_in_if  in_if ();
  sfa_out_if out_if ();

  saturating_fixed_point_alu #(.FRAC_BITS(FRAC)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint clamp_fx(longint v, ref logic sat);
    if (v > LIM_HI) begin
      sat = 1'b1;
      return LIM_HI;
    end
    if (v < LIM_LO) begin
      sat = 1'b1;
      return LIM_LO;
    end
    return v;
  endfunction

  function automatic alu_result_t compute_alu(logic [3:0] cmd, logic [31:0] a_bits,
                                              logic [31:0] b_bits);
    alu_result_t r;
    longint a;
    longint b;
    longint v;
    a = longint'(signed'(a_bits));
    b = longint'(signed'(b_bits));
    v = 0;
    r = '{default: 1'b0};
    case (cmd)
      CMD_ADD: v = clamp_fx(a + b, r.saturated);
      CMD_SUB: v = clamp_fx(a - b, r.saturated);
      // Division on longint truncates toward zero, as the scaling requires.
      CMD_MUL: v = clamp_fx((a * b) / (64'sd1 << FRAC), r.saturated);
      CMD_DIV: begin
        if (b == 0) r.divide_by_zero = 1'b1;
        else v = clamp_fx((a * (64'sd1 << FRAC)) / b, r.saturated);
      end
      CMD_FROM_INT: begin
        if (a > LIM_HI / (64'sd1 << FRAC)) begin
          v = LIM_HI;
          r.saturated = 1'b1;
        end else if (a < LIM_LO / (64'sd1 << FRAC)) begin
          v = LIM_LO;
          r.saturated = 1'b1;
        end else begin
          v = a * (64'sd1 << FRAC);
        end
      end
      CMD_TO_INT: v = a / (64'sd1 << FRAC);
      CMD_COMPARE: begin
        r.less = a < b;
        r.equal = a == b;
        r.greater = a > b;
      end
      CMD_MIN: v = (a < b) ? a : b;
      CMD_MAX: v = (a > b) ? a : b;
      CMD_INC: v = a + 1;
      CMD_DEC: v = a - 1;
      default: v = 0;
    endcase
    r.result = v[31:0];
    return r;
  endfunction

  // Result side: random stalls, checked against the oldest prediction.
  always @(negedge clk_i) begin
    if (!rst_ni) out_if.ready <= 1'b0;
    else out_if.ready <= no_idle || ($urandom_range(99) >= 21);
  end

  always @(posedge clk_i) begin
    alu_result_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no operation outstanding");
        fail_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_if.result !== exp_r.result) begin
          $error("result: expected %h, got %h", exp_r.result, out_if.result);
          fail_cnt++;
        end
        if (out_if.saturated !== exp_r.saturated) begin
          $error("saturated: expected %b, got %b", exp_r.saturated, out_if.saturated);
          fail_cnt++;
        end
        if (out_if.divide_by_zero !== exp_r.divide_by_zero) begin
          $error("divide_by_zero: expected %b, got %b", exp_r.divide_by_zero,
                 out_if.divide_by_zero);
          fail_cnt++;
        end
        if (out_if.less !== exp_r.less) begin
          $error("less: expected %b, got %b", exp_r.less, out_if.less);
          fail_cnt++;
        end
        if (out_if.equal !== exp_r.equal) begin
          $error("equal: expected %b, got %b", exp_r.equal, out_if.equal);
          fail_cnt++;
        end
        if (out_if.greater !== exp_r.greater) begin
          $error("greater: expected %b, got %b", exp_r.greater, out_if.greater);
          fail_cnt++;
        end
      end
    end
  end

  // Drives one operation, with an optional random gap first, and waits for its transfer.
  // Valid stays high afterwards; the next gap or the drain wait lowers it.
  task automatic send_op(logic [3:0] cmd, logic [31:0] a, logic [31:0] b);
    while (!no_idle && $urandom_range(99) < 21) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.command   <= cmd;
    in_if.operand_a <= a;
    in_if.operand_b <= b;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(compute_alu(cmd, a, b));
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? FX_MAX : FX_MIN;
      1: return 32'($urandom_range(1023)) - 32'd512;
      2: return {{16{1'b0}}, 16'($urandom)} << $urandom_range(15);
      3: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_arith_extremes();
    send_op(CMD_ADD, FX_MAX, 32'd1);
    send_op(CMD_ADD, FX_MIN, FX_MIN);
    send_op(CMD_SUB, FX_MIN, 32'd1);
    send_op(CMD_SUB, FX_MAX, FX_MIN);
    send_op(CMD_MUL, FX_MAX, FX_MAX);
    send_op(CMD_MUL, FX_MIN, FX_MAX);
    send_op(CMD_MUL, 32'hffff_ff01, 32'h0000_0080);
    send_op(CMD_DIV, FX_MAX, 32'd1);
    send_op(CMD_DIV, FX_MIN, 32'hffff_ffff);
    send_op(CMD_DIV, 32'hffff_fd00, 32'd700);
  endtask

  task automatic test_special_cases();
    send_op(CMD_DIV, 32'd1234, 32'd0);
    send_op(CMD_DIV, 32'd0, 32'd0);
    send_op(CMD_FROM_INT, 32'h007f_ffff, 32'd0);
    send_op(CMD_FROM_INT, 32'h0080_0000, 32'd0);
    send_op(CMD_FROM_INT, 32'hff80_0000, 32'd0);
    send_op(CMD_FROM_INT, 32'hff7f_ffff, 32'd0);
    send_op(CMD_TO_INT, 32'hffff_ff01, 32'd0);
    send_op(CMD_TO_INT, FX_MIN, 32'd0);
    send_op(CMD_COMPARE, 32'd5, 32'd5);
    send_op(CMD_COMPARE, FX_MIN, FX_MAX);
    send_op(CMD_COMPARE, FX_MAX, FX_MIN);
    send_op(CMD_MIN, FX_MIN, FX_MAX);
    send_op(CMD_MAX, FX_MIN, FX_MAX);
    send_op(CMD_INC, FX_MAX, 32'd0);
    send_op(CMD_DEC, FX_MIN, 32'd0);
    send_op(4'd11, 32'd7, 32'd9);
    send_op(4'd15, FX_MAX, FX_MAX);
  endtask

  // Divides are drawn as often as any other defined command; each occupies the back end.
  task automatic test_random_ops(int count);
    logic [3:0] cmd;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 3) cmd = 4'(11 + $urandom_range(4));
      else cmd = 4'($urandom_range(10));
      send_op(cmd, pick_operand(), pick_operand());
    end
  endtask

  initial begin
    in_if.valid     = 1'b0;
    in_if.command   = CMD_ADD;
    in_if.operand_a = '0;
    in_if.operand_b = '0;
    out_if.ready    = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_arith_extremes();
    test_special_cases();
    test_random_ops(500);
    // Sender holds off until the pipeline has emptied.
    wait_drained();
    no_idle = 1'b1;
    test_random_ops(300);
    no_idle = 1'b0;
    test_random_ops(520);

    wait_drained();
    repeat (60) @(negedge clk_i);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
